/* hw/rtl/alu8f_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_pkg
// Operation codes, status byte layout and item types for the 8-bit ALU.
// ----------------------------------------------------------------------------
package alu8f_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned OpW   = 5;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_SUB = 5'd2,
    OP_SBB = 5'd3,
    OP_ANA = 5'd4,
    OP_XRA = 5'd5,
    OP_ORA = 5'd6,
    OP_CMP = 5'd7,
    OP_DAA = 5'd8,
    OP_INR = 5'd9,
    OP_DCR = 5'd10,
    OP_RLC = 5'd11,
    OP_RRC = 5'd12,
    OP_RAL = 5'd13,
    OP_RAR = 5'd14,
    OP_CMA = 5'd15,
    OP_STC = 5'd16,
    OP_CMC = 5'd17
  } op_e;

  // status byte bit positions
  localparam int unsigned FlS  = 7;
  localparam int unsigned FlZ  = 6;
  localparam int unsigned FlX5 = 5;
  localparam int unsigned FlAc = 4;
  localparam int unsigned FlP  = 2;
  localparam int unsigned FlV  = 1;
  localparam int unsigned FlCy = 0;

  typedef struct packed {
    logic [DataW-1:0] flags_in;
    logic [DataW-1:0] operand;
    logic [DataW-1:0] acc_value;
    logic [OpW-1:0]   op;
  } alu8f_item_t;

  typedef struct packed {
    logic [DataW-1:0] flags_out;
    logic [DataW-1:0] result;
  } alu8f_res_t;

  // even parity flag: set when the byte has an even number of ones
  function automatic logic even_par(input logic [DataW-1:0] b);
    even_par = ~^b;
  endfunction

endpackage

/* hw/rtl/alu8f_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8f_core
// Combinational datapath: shared adder, logic unit, decimal adjust, rotates and flags.
// ----------------------------------------------------------------------------
module alu8f_core (
  input  alu8f_pkg::alu8f_item_t item_i,
  input  logic                   model_8085_i,
  output alu8f_pkg::alu8f_res_t  res_o
);
  import alu8f_pkg::*;

  logic [DataW-1:0] a, v, fi, w, r, f, add_r, d;
  logic [DataW:0]   sum9;
  logic [4:0]       sum4;
  logic             k, cy, is_sub, cin, ac, lo_big, maj, bit1;
  op_e              op;

  always_comb begin
    a   = item_i.acc_value;
    v   = item_i.operand;
    fi  = item_i.flags_in;
    op  = op_e'(item_i.op);
    k   = model_8085_i;
    cy  = fi[FlCy];
    bit1 = ~k;

    // shared adder for add / subtract / compare
    is_sub = (op == OP_SUB) || (op == OP_SBB) || (op == OP_CMP);
    w      = is_sub ? ~v : v;
    unique case (op)
      OP_ADC:  cin = cy;
      OP_SBB:  cin = ~cy;
      OP_SUB,
      OP_CMP:  cin = 1'b1;
      default: cin = 1'b0;
    endcase
    sum4  = {1'b0, a[3:0]} + {1'b0, w[3:0]} + {4'b0, cin};
    sum9  = {1'b0, a} + {1'b0, w} + {{DataW{1'b0}}, cin};
    add_r = sum9[DataW-1:0];

    lo_big = a[3:0] > 4'd9;
    d      = '0;
    if (fi[FlAc] || lo_big) d = d + 8'h06;
    if (cy || (a >= 8'h9A)) d = d + 8'h60;

    r   = a;
    f   = fi;
    ac  = 1'b0;
    maj = 1'b0;

    unique case (op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP: begin
        r    = (op == OP_CMP) ? a : add_r;
        maj  = k & ((a[7] & v[7]) | (a[7] & add_r[7]) | (v[7] & add_r[7]));
        bit1 = k ? ((a[7] & w[7] & ~add_r[7]) | (~a[7] & ~w[7] & add_r[7])) : 1'b1;
        f    = {add_r[7], add_r == '0, maj, sum4[4], 1'b0, even_par(add_r), bit1,
                sum9[DataW] ^ is_sub};
      end
      OP_ANA, OP_XRA, OP_ORA: begin
        if (op == OP_ANA) begin
          r  = a & v;
          ac = k | a[3] | v[3];
        end else if (op == OP_XRA) begin
          r    = a ^ v;
          bit1 = k ? fi[FlV] : 1'b1;
        end else begin
          r = a | v;
        end
        maj = k & ((a[7] & v[7]) | (a[7] & r[7]) | (v[7] & r[7]));
        f   = {r[7], r == '0, maj, ac, 1'b0, even_par(r), bit1, 1'b0};
      end
      OP_DAA: begin
        r = a + d;
        f = {r[7], r == '0, 1'b0, lo_big, 1'b0, even_par(r), bit1, cy | (a >= 8'h9A)};
      end
      OP_INR: begin
        r = a + 8'd1;
        f = {r[7], r == '0, 1'b0, r[3:0] == 4'h0, 1'b0, even_par(r), bit1, cy};
      end
      OP_DCR: begin
        r = a - 8'd1;
        f = {r[7], r == '0, 1'b0, r[3:0] != 4'hF, 1'b0, even_par(r), bit1, cy};
      end
      OP_RLC: begin
        r = {a[6:0], a[7]};
        f = {fi[7:1], a[7]};
      end
      OP_RAL: begin
        r = {a[6:0], cy};
        f = {fi[7:1], a[7]};
      end
      OP_RRC, OP_RAR: begin
        r = {(op == OP_RRC) ? a[0] : cy, a[7:1]};
        f = {fi[7:2], fi[FlV] & ~k, a[0]};
      end
      OP_CMA: r = ~a;
      OP_STC: f = {fi[7:1], 1'b1};
      OP_CMC: f = {fi[7:1], ~cy};
      default: begin
        // unused codes pass the item through
        r = a;
        f = fi;
      end
    endcase

    res_o.result    = r;
    res_o.flags_out = f;
  end

endmodule

/* hw/rtl/alu_8bit_with_flags_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_8bit_with_flags_unit
// 8-bit accumulator ALU with 8080/8085 status flag rules.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on the s_axis channel: tuser carries the operation,
//   tdata the accumulator, operand and status byte. Each item yields one
//   item on m_axis with the new value and status byte.
//   An item is captured in the input register, the datapath computes in
//   one pass and the result register presents it: m_axis_tvalid rises when
//   the result register loads the item, and the result is taken while
//   m_axis_tready is high. One item per cycle is sustained while the
//   receiver keeps m_axis_tready high; both registers advance together.
//   When the receiver holds m_axis_tready low the result register keeps its
//   item, the input register fills, and s_axis_tready drops only once both
//   are occupied.
//   cfg_we_i / cfg_wdata_i write the model select (1 = 8085 rules); write it
//   only while no items are in flight.
//   Reset empties both registers and selects 8080 rules.
// ----------------------------------------------------------------------------
module alu_8bit_with_flags_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // model_8085
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // acc_value[7:0], operand[15:8], flags_in[23:16]
  input  logic [4:0]  s_axis_tuser,   // op[4:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // result[7:0], flags_out[15:8]
);
  import alu8f_pkg::*;

  logic        model_q;
  logic        in_vld_q, out_vld_q;
  alu8f_item_t in_q, in_d;
  alu8f_res_t  out_q, res;
  logic        out_ready, in_load;

  assign out_ready     = ~out_vld_q | m_axis_tready;
  assign s_axis_tready = ~in_vld_q | out_ready;
  assign in_load       = s_axis_tvalid & s_axis_tready;

  always_comb begin
    in_d.op        = s_axis_tuser;
    in_d.acc_value = s_axis_tdata[7:0];
    in_d.operand   = s_axis_tdata[15:8];
    in_d.flags_in  = s_axis_tdata[23:16];
  end

  alu8f_core u_core (
    .item_i       (in_q),
    .model_8085_i (model_q),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q   <= 1'b0;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) model_q <= cfg_wdata_i;
      if (s_axis_tready) in_vld_q <= s_axis_tvalid;
      if (out_ready) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) in_q <= in_d;
    if (out_ready && in_vld_q) out_q <= res;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.flags_out, out_q.result};

endmodule
